// ===== sv/aik_pkg.sv =====
// aik_pkg: shared types, constants and helper functions for arm_inverse_kinematics.
// No dependencies.
package aik_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;
  localparam int W                = 32;  // CORDIC x/y width
  localparam int AW               = 26;  // angle width, 1/256 centidegree
  localparam int REG_W            = 14;
  localparam int LEN_W            = 22;  // link length in Q14.8
  localparam int SQ_W             = 44;  // squared length
  localparam int REM_W            = 26;
  localparam int ANG_W            = 28;
  localparam int INV_GAIN         = 39797;
  localparam logic signed [AW-1:0] HALF_TURN = AW'(18000 * 256);

  typedef enum logic [1:0] {
    REG_BASE_HEIGHT,
    REG_LINK_LENGTH,
    REG_TOOL_SIDE,
    REG_TOOL_DROP
  } reg_idx_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic signed [W-1:0]  x;
    logic signed [W-1:0]  y;
    logic signed [AW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic             valid;
    logic [SQ_W-1:0]  n;
    logic [REM_W-1:0] rem;
    logic [LEN_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic                 ok;
    logic [LEN_W-1:0]     a;
    logic signed [AW-1:0] beta;
    logic signed [AW-1:0] phi;
    logic signed [AW-1:0] eps;
    logic                 e_pos;
  } side_t;

  function automatic logic signed [AW-1:0] atan_val(input int unsigned i);
    logic signed [AW-1:0] r;
    begin
      case (i)
        0:  r = AW'(1152000);
        1:  r = AW'(680065);
        2:  r = AW'(359328);
        3:  r = AW'(182400);
        4:  r = AW'(91554);
        5:  r = AW'(45822);
        6:  r = AW'(22916);
        7:  r = AW'(11459);
        8:  r = AW'(5730);
        9:  r = AW'(2865);
        10: r = AW'(1432);
        11: r = AW'(716);
        12: r = AW'(358);
        13: r = AW'(179);
        14: r = AW'(90);
        15: r = AW'(45);
        16: r = AW'(22);
        17: r = AW'(11);
        18: r = AW'(6);
        19: r = AW'(3);
        20: r = AW'(1);
        21: r = AW'(1);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // round half up to centidegrees and saturate to +/-lim
  function automatic logic signed [17:0] to_cdeg(input logic signed [ANG_W-1:0] v,
                                                 input logic signed [17:0] lim);
    logic signed [ANG_W-1:0] t;
    logic signed [ANG_W-1:0] l;
    logic signed [17:0]      r;
    begin
      t = (v + ANG_W'(128)) >>> 8;
      l = ANG_W'(lim);
      if (t > l) r = lim;
      else if (t < -l) r = -lim;
      else r = t[17:0];
      return r;
    end
  endfunction

endpackage

// ===== sv/aik_cordic_cell.sv =====
// aik_cordic_cell: one registered vectoring CORDIC micro-rotation.
// Depends on aik_pkg.
module aik_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  aik_pkg::cord_t d,
  output aik_pkg::cord_t q
);

  aik_pkg::cord_t q_next;
  logic signed [aik_pkg::W-1:0] xs, ys;

  always_comb begin
    xs = d.x >>> STEP;
    ys = d.y >>> STEP;
    q_next = d;
    if (!d.y[aik_pkg::W-1]) begin
      q_next.x = d.x + ys;
      q_next.y = d.y - xs;
      q_next.z = d.z + aik_pkg::atan_val(STEP);
    end else begin
      q_next.x = d.x - ys;
      q_next.y = d.y + xs;
      q_next.z = d.z - aik_pkg::atan_val(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= q_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.zero <= q_next.zero;
      q.x    <= q_next.x;
      q.y    <= q_next.y;
      q.z    <= q_next.z;
    end
  end

endmodule

// ===== sv/aik_vector.sv =====
// aik_vector: quadrant fold, chain of CORDIC cells and gain correction.
// Gives magnitude and angle of (x, y); depends on aik_pkg, aik_cordic_cell.
module aik_vector #(
  parameter int STEPS = aik_pkg::CORDIC_STEPS_DEF,
  parameter int SBW   = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [aik_pkg::W-1:0]   in_x,
  input  logic signed [aik_pkg::W-1:0]   in_y,
  input  logic [SBW-1:0]                 in_sb,
  output logic                           out_valid,
  output logic signed [aik_pkg::W-1:0]   out_mag,
  output logic signed [aik_pkg::AW-1:0]  out_ang,
  output logic [SBW-1:0]                 out_sb
);

  aik_pkg::cord_t stg [0:STEPS];
  logic [SBW-1:0] sb  [0:STEPS];
  aik_pkg::cord_t fold;
  logic [aik_pkg::W-1:0] xc;
  logic [47:0] prod;

  always_comb begin
    fold.valid = in_valid;
    fold.zero  = (in_x == '0) && (in_y == '0);
    fold.x     = in_x;
    fold.y     = in_y;
    fold.z     = '0;
    if (in_x[aik_pkg::W-1]) begin
      fold.x = -in_x;
      fold.y = -in_y;
      fold.z = in_y[aik_pkg::W-1] ? -aik_pkg::HALF_TURN : aik_pkg::HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else if (en) begin
      stg[0].valid <= fold.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].zero <= fold.zero;
      stg[0].x    <= fold.x;
      stg[0].y    <= fold.y;
      stg[0].z    <= fold.z;
      sb[0]       <= in_sb;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    aik_cordic_cell #(.STEP(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (stg[i]),
      .q   (stg[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sb[i+1] <= sb[i];
      end
    end
  end

  always_comb begin
    xc   = stg[STEPS].x[aik_pkg::W-1] ? '0 : stg[STEPS].x;
    prod = {16'b0, xc} * 48'(aik_pkg::INV_GAIN) + 48'd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= stg[STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mag <= stg[STEPS].zero ? '0 : prod[47:16];
      out_ang <= stg[STEPS].zero ? '0 : stg[STEPS].z;
      out_sb  <= sb[STEPS];
    end
  end

endmodule

// ===== sv/aik_sqrt_cell.sv =====
// aik_sqrt_cell: one restoring square-root digit step, registered.
// Depends on aik_pkg.
module aik_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  aik_pkg::sqrt_t d,
  output aik_pkg::sqrt_t q
);

  logic [aik_pkg::REM_W-1:0] rem_s, trial;
  aik_pkg::sqrt_t q_next;

  always_comb begin
    rem_s  = {d.rem[aik_pkg::REM_W-3:0], d.n[aik_pkg::SQ_W-1 -: 2]};
    trial  = aik_pkg::REM_W'({d.root, 2'b01});
    q_next = d;
    q_next.n = {d.n[aik_pkg::SQ_W-3:0], 2'b00};
    if (rem_s >= trial) begin
      q_next.rem  = rem_s - trial;
      q_next.root = {d.root[aik_pkg::LEN_W-2:0], 1'b1};
    end else begin
      q_next.rem  = rem_s;
      q_next.root = {d.root[aik_pkg::LEN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= q_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.n    <= q_next.n;
      q.rem  <= q_next.rem;
      q.root <= q_next.root;
    end
  end

endmodule

// ===== sv/aik_delay.sv =====
// aik_delay: enabled shift line that carries side data beside a pipeline.
// No dependencies.
module aik_delay #(
  parameter int DW    = 8,
  parameter int DEPTH = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] d,
  output logic [DW-1:0] q
);

  logic [DW-1:0] tap [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
    end
  end

  for (genvar i = 1; i < DEPTH; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

// ===== sv/arm_inverse_kinematics.sv =====
// arm_inverse_kinematics: pipelined inverse kinematics of a yaw base with two equal links.
// Chains in order: base CORDIC, wrist and phi CORDICs side by side, 22 sqrt cells, alpha CORDIC.
// Throughput one transfer per cycle; the whole pipeline holds while a result waits.
// Synchronous active-high reset clears valid bits and loads the register defaults.
// Depends on aik_pkg, aik_vector, aik_sqrt_cell, aik_delay.
module arm_inverse_kinematics #(
  parameter int CORDIC_STEPS = aik_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // target_x, target_y, target_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // reach_ok, base_yaw, shoulder_angle, elbow_angle,
                                 // wrist_angle, zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int W  = aik_pkg::W;
  localparam int AW = aik_pkg::AW;
  localparam int LW = aik_pkg::LEN_W;

  logic adv;
  logic [13:0] base_height, link_length, tool_side_offset, tool_drop_offset;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_height      <= 14'd1600;
      link_length      <= 14'd3200;
      tool_side_offset <= 14'd592;
      tool_drop_offset <= 14'd1280;
    end else if (cfg_we) begin
      unique case (aik_pkg::reg_idx_t'(cfg_index))
        aik_pkg::REG_BASE_HEIGHT: base_height      <= cfg_data;
        aik_pkg::REG_LINK_LENGTH: link_length      <= cfg_data;
        aik_pkg::REG_TOOL_SIDE:   tool_side_offset <= cfg_data;
        aik_pkg::REG_TOOL_DROP:   tool_drop_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // base yaw and horizontal radius
  logic              v1_valid;
  logic signed [W-1:0]  radius;
  logic signed [AW-1:0] eps;
  logic [15:0]       v1_z;

  aik_vector #(.STEPS(CORDIC_STEPS), .SBW(16)) u_vec_base (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_tvalid),
    .in_x      ({{8{s_tdata[15]}}, s_tdata[15:0], 8'h00}),
    .in_y      ({{8{s_tdata[31]}}, s_tdata[31:16], 8'h00}),
    .in_sb     (s_tdata[47:32]),
    .out_valid (v1_valid),
    .out_mag   (radius),
    .out_ang   (eps),
    .out_sb    (v1_z)
  );

  // wrist offset in the arm plane
  logic                 b_valid;
  logic signed [W-1:0]  d_r, e_r, e_sum;
  logic signed [AW-1:0] b_eps;

  assign e_sum = {{16{v1_z[15]}}, v1_z} + W'(tool_drop_offset) - W'(base_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= v1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r   <= radius - {10'b0, tool_side_offset, 8'h00};
      e_r   <= e_sum <<< 8;
      b_eps <= eps;
    end
  end

  logic                 v2_valid, v3_valid;
  logic signed [W-1:0]  w_mag, phi_mag;
  logic signed [AW-1:0] beta, phi, v2_eps;
  logic                 v3_epos;

  aik_vector #(.STEPS(CORDIC_STEPS), .SBW(AW)) u_vec_wrist (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b_valid),
    .in_x      (d_r),
    .in_y      (e_r),
    .in_sb     (b_eps),
    .out_valid (v2_valid),
    .out_mag   (w_mag),
    .out_ang   (beta),
    .out_sb    (v2_eps)
  );

  aik_vector #(.STEPS(CORDIC_STEPS), .SBW(1)) u_vec_phi (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b_valid),
    .in_x      (e_r),
    .in_y      (d_r),
    .in_sb     (e_r > 0),
    .out_valid (v3_valid),
    .out_mag   (phi_mag),
    .out_ang   (phi),
    .out_sb    (v3_epos)
  );

  // reach window and half distance
  logic [39:0]     w_x100, reach_hi;
  logic [W-1:0]    reach_lo;
  logic [LW-1:0]   len_q12;
  logic [W-1:0]    half_w;
  logic            c_valid;
  aik_pkg::side_t  c_side;

  always_comb begin
    len_q12  = {link_length, 8'h00};
    w_x100   = 40'(w_mag) * 40'd100;
    reach_hi = 40'(link_length) * 40'(195 * 256);
    reach_lo = W'({tool_drop_offset + 15'd160, 8'h00});
    half_w   = W'(w_mag >>> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= v2_valid && v3_valid && (phi_mag >= 0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side.ok    <= !(W'(w_mag) < reach_lo) && !(w_x100 > reach_hi);
      c_side.a     <= (half_w > W'(len_q12)) ? len_q12 : half_w[LW-1:0];
      c_side.beta  <= beta;
      c_side.phi   <= phi;
      c_side.eps   <= v2_eps;
      c_side.e_pos <= v3_epos;
    end
  end

  // squares, difference, then the root chain
  logic                  dd_valid, ee_valid;
  logic [aik_pkg::SQ_W-1:0] ll_sq, aa_sq, n_diff;
  aik_pkg::side_t        dd_side, ee_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      dd_valid <= 1'b0;
      ee_valid <= 1'b0;
    end else if (adv) begin
      dd_valid <= c_valid;
      ee_valid <= dd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ll_sq   <= len_q12 * len_q12;
      aa_sq   <= c_side.a * c_side.a;
      dd_side <= c_side;
      n_diff  <= ll_sq - aa_sq;
      ee_side <= dd_side;
    end
  end

  aik_pkg::sqrt_t sq [0:LW];
  aik_pkg::side_t sq_side;

  always_comb begin
    sq[0].valid = ee_valid;
    sq[0].n     = n_diff;
    sq[0].rem   = '0;
    sq[0].root  = '0;
  end

  for (genvar i = 0; i < LW; i++) begin : g_sqrt
    aik_sqrt_cell u_sq (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (sq[i]),
      .q   (sq[i+1])
    );
  end

  aik_delay #(.DW($bits(aik_pkg::side_t)), .DEPTH(LW)) u_side_dly (
    .clk (clk),
    .en  (adv),
    .d   (ee_side),
    .q   (sq_side)
  );

  // elbow half angle
  logic                 v4_valid;
  logic signed [W-1:0]  v4_mag;
  logic signed [AW-1:0] alpha;
  aik_pkg::side_t       f_side;

  aik_vector #(.STEPS(CORDIC_STEPS), .SBW($bits(aik_pkg::side_t))) u_vec_alpha (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sq[LW].valid),
    .in_x      (W'(sq_side.a)),
    .in_y      (W'(sq[LW].root)),
    .in_sb     (sq_side),
    .out_valid (v4_valid),
    .out_mag   (v4_mag),
    .out_ang   (alpha),
    .out_sb    (f_side)
  );

  // final angles
  logic signed [aik_pkg::ANG_W-1:0] al, be, ph, tau, gam, lam, ht;
  logic signed [17:0] yaw_c, tau_c, gam_c, lam_c;
  logic [66:0] res;

  always_comb begin
    al  = aik_pkg::ANG_W'(alpha);
    be  = aik_pkg::ANG_W'(f_side.beta);
    ph  = aik_pkg::ANG_W'(f_side.phi);
    ht  = aik_pkg::ANG_W'(aik_pkg::HALF_TURN);
    tau = f_side.e_pos ? al + be : al - be;
    gam = ht - (al <<< 1);
    lam = ht - al - ph;
    yaw_c = aik_pkg::to_cdeg(aik_pkg::ANG_W'(f_side.eps), 18'sd18000);
    tau_c = aik_pkg::to_cdeg(tau, 18'sd36000);
    gam_c = aik_pkg::to_cdeg(gam, 18'sd18000);
    lam_c = aik_pkg::to_cdeg(lam, 18'sd36000);
    if (f_side.ok) begin
      res = {lam_c[16:0], gam_c[15:0], tau_c[16:0], yaw_c[15:0], 1'b1};
    end else begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v4_valid && (v4_mag >= 0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {5'b0, res};
    end
  end

endmodule

// ===== sv/aik_checker.sv =====
// aik_checker: port-level checks for arm_inverse_kinematics, bound to the top level.
// No dependencies besides the bound module's ports.
module aik_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input refused while output free");

  a_unreach: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[71:1] == '0)
    else $error("angles nonzero outside reach window");

endmodule

bind arm_inverse_kinematics aik_checker u_aik_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/aik_checker.sv =====
`timescale 1ns / 100ps
// aik_scoreboard: watches the target and joint-angle streams of arm_inverse_kinematics,
// predicts each result from its own copy of the geometry registers and compares.
// Depends on aik_pkg.
module aik_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam longint HALF = 18000 * 256;

  typedef struct {
    bit                 ok;
    logic signed [15:0] yaw;
    logic signed [16:0] shoulder;
    logic signed [15:0] elbow;
    logic signed [16:0] wrist;
  } joints_t;

  longint atan_lut[24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                           5730, 2865, 1432, 716, 358, 179, 90, 45,
                           22, 11, 6, 3, 1, 1, 0, 0};

  longint height, link, side, drop;
  joints_t joints_q[$];

  function automatic void cordic_vec(input longint xi, input longint yi,
                                     output longint mag, output longint ang);
    longint x, y, z, xs, ys;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? HALF : -HALF;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < aik_pkg::CORDIC_STEPS_DEF && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_lut[i];
      end else begin
        x = x - ys; y = y + xs; z -= atan_lut[i];
      end
    end
    if (x < 0) x = 0;
    mag = (x * aik_pkg::INV_GAIN + 32768) >>> 16;
    ang = z;
  endfunction

  function automatic longint root64(input bit [63:0] n);
    bit [63:0] res, bitv, rem;
    rem = n;
    res = 0;
    for (int i = 0; i < 32; i++) begin
      bitv = 64'd1 << (62 - 2 * i);
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return longint'(res);
  endfunction

  function automatic longint centideg(input longint v, input longint lim);
    longint r;
    r = (v + 128) >>> 8;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic joints_t solve_joints(input logic [47:0] d);
    joints_t j;
    longint x, y, z, radius, eps, dd, e, w, beta, tmp, phi, a, ll, s, alpha;
    x = longint'($signed(d[15:0])) * 256;
    y = longint'($signed(d[31:16])) * 256;
    z = longint'($signed(d[47:32]));
    j = '{0, 0, 0, 0, 0};
    cordic_vec(x, y, radius, eps);
    dd = radius - side * 256;
    e = (z + drop - height) * 256;
    cordic_vec(dd, e, w, beta);
    cordic_vec(e, dd, tmp, phi);
    if (w < (drop + 160) * 256 || w * 100 > 195 * link * 256) return j;
    ll = link * 256;
    a = w >>> 1;
    if (a > ll) a = ll;
    if (a < 0) a = 0;
    s = root64(64'(ll * ll - a * a));
    cordic_vec(a, s, tmp, alpha);
    j.ok = 1;
    j.yaw = 16'(centideg(eps, 18000));
    j.shoulder = 17'(centideg((e > 0) ? alpha + beta : alpha - beta, 36000));
    j.elbow = 16'(centideg(HALF - 2 * alpha, 18000));
    j.wrist = 17'(centideg(HALF - alpha - phi, 36000));
    return j;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    joints_t want;
    if (rst) begin
      height = 1600;
      link = 3200;
      side = 592;
      drop = 1280;
      joints_q.delete();
    end else begin
      if (cfg_we) begin
        case (aik_pkg::reg_idx_t'(cfg_index))
          aik_pkg::REG_BASE_HEIGHT: height = cfg_data;
          aik_pkg::REG_LINK_LENGTH: link = cfg_data;
          aik_pkg::REG_TOOL_SIDE:   side = cfg_data;
          aik_pkg::REG_TOOL_DROP:   drop = cfg_data;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (joints_q.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          want = joints_q.pop_front();
          if (m_tdata[0] != want.ok) report_mismatch("reach_ok", m_tdata[0], want.ok);
          if ($signed(m_tdata[16:1]) != want.yaw)
            report_mismatch("base_yaw", $signed(m_tdata[16:1]), want.yaw);
          if ($signed(m_tdata[33:17]) != want.shoulder)
            report_mismatch("shoulder_angle", $signed(m_tdata[33:17]), want.shoulder);
          if ($signed(m_tdata[49:34]) != want.elbow)
            report_mismatch("elbow_angle", $signed(m_tdata[49:34]), want.elbow);
          if ($signed(m_tdata[66:50]) != want.wrist)
            report_mismatch("wrist_angle", $signed(m_tdata[66:50]), want.wrist);
          if (m_tdata[71:67] !== 5'b0) report_mismatch("zero fill", m_tdata[71:67], 0);
        end
      end
      if (s_tvalid && s_tready) joints_q.push_back(solve_joints(s_tdata));
    end
    pending = joints_q.size();
  end

endmodule

// ===== sim/tb_arm_inverse_kinematics.sv =====
`timescale 1ns / 100ps
// tb_arm_inverse_kinematics: stimulus and verdict for arm_inverse_kinematics.
// Drives targets and register writes; aik_scoreboard does prediction and comparison.
module tb_arm_inverse_kinematics;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = aik_pkg::REG_BASE_HEIGHT;
  logic [13:0] cfg_data = '0;
  int          errors, pending;
  int          send_idle, recv_idle;
  int          span, hgt;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  arm_inverse_kinematics DUT (.*);

  aik_scoreboard u_scoreboard (.*);

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

  task automatic write_geometry(input int bh, input int ll, input int ts, input int td);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= aik_pkg::REG_BASE_HEIGHT; cfg_data <= 14'(bh);
    @(posedge clk);
    cfg_index <= aik_pkg::REG_LINK_LENGTH; cfg_data <= 14'(ll);
    @(posedge clk);
    cfg_index <= aik_pkg::REG_TOOL_SIDE; cfg_data <= 14'(ts);
    @(posedge clk);
    cfg_index <= aik_pkg::REG_TOOL_DROP; cfg_data <= 14'(td);
    @(posedge clk);
    cfg_we <= 0;
    span = 2 * ll + ts + td + 400;
    if (span > 32767) span = 32767;
    hgt = bh - td;
  endtask

  task automatic send_target(input int x, input int y, input int z);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {16'(z), 16'(y), 16'(x)};
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (100) @(posedge clk);
  endtask

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int near(input int center);
    return clip16(center + $urandom_range(0, 2 * span) - span);
  endfunction

  task automatic random_targets(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 75)
        send_target(near(0), near(0), near(hgt));
      else
        send_target($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768);
    end
  endtask

  initial begin
    send_idle = 28;
    recv_idle = 78;
    repeat (4) @(posedge clk);
    rst <= 0;
    write_geometry(1600, 3200, 592, 1280);

    // corners, zero vector, negative x axis, wrist level with shoulder, edge of reach
    send_target(0, 0, 0);
    send_target(-32768, -32768, -32768);
    send_target(32767, 32767, 32767);
    send_target(-32768, 32767, 0);
    send_target(32767, -32768, 0);
    send_target(-5000, 0, 320);
    send_target(-5000, 0, 1000);
    send_target(0, 0, 320);
    send_target(592, 0, 320);
    send_target(4592, 0, 320);
    send_target(0, 4592, 320);
    send_target(0, -4592, 320);
    send_target(-4592, 0, 320);
    send_target(592 + 6200, 0, 320);
    send_target(592 + 6300, 0, 320);
    send_target(592 + 2400, 0, 320);
    send_target(592 + 2600, 0, 320);
    send_target(592 + 1000, 0, 320 + 4000);
    send_target(592 + 1000, 0, 320 - 4000);
    send_target(592, 0, 320 + 3000);
    send_target(3000, 3000, -2000);
    send_target(-3000, -3000, 2000);
    send_target(-1, 0, 320);
    random_targets(550);
    drain();

    send_idle = 78;
    recv_idle = 28;
    write_geometry(16383, 16383, 0, 0);
    random_targets(450);
    drain();
    write_geometry(0, 1, 16383, 16383);
    random_targets(150);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_geometry($urandom_range(0, 16383), $urandom_range(1500, 9000),
                   $urandom_range(0, 3000), $urandom_range(0, 3000));
    random_targets(300);
    drain();
    write_geometry(800, 5000, 300, 0);
    random_targets(300);
    drain();

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/aik_pkg.sv
sv/aik_cordic_cell.sv
sv/aik_vector.sv
sv/aik_sqrt_cell.sv
sv/aik_delay.sv
sv/arm_inverse_kinematics.sv
sv/aik_checker.sv
sim/aik_checker.sv
sim/tb_arm_inverse_kinematics.sv
